/* rtl/mandelbrot_pixel_colour_macros.svh */
// Assertion macros for the Mandelbrot pixel colour block.
`ifndef MANDELBROT_PIXEL_COLOUR_MACROS_SVH
`define MANDELBROT_PIXEL_COLOUR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mpc_pkg.sv */
// Types, constants and helpers shared by the Mandelbrot pixel colour block.
package mpc_pkg;

  localparam int COLOUR_LEVELS = 256;
  localparam int MAX_SAMPLES   = 8;

  localparam int ITER_W     = 16;
  localparam int CX_W       = 32;
  localparam int SCALE_W    = 31;
  localparam int S_CFG_W    = 4;
  localparam int DIM_W      = 13;
  localparam int PIX_W      = 12;
  localparam int COLOUR_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_BITS  = 28;

  localparam int S_W     = $clog2(MAX_SAMPLES + 1);
  localparam int SS_W    = 2 * S_W;
  localparam int DIMS_W  = DIM_W + S_W;
  localparam int PXS_W   = PIX_W + S_W;
  localparam int CNT_W   = ITER_W + 1;
  localparam int TOT_W   = ITER_W + SS_W;
  localparam int LVL_W   = $clog2(COLOUR_LEVELS);
  localparam int CL_W    = $clog2(COLOUR_LEVELS + 1);
  localparam int PRD_W   = PXS_W + SCALE_W;
  localparam int DIV_NW  = SCALE_W + DIM_W;
  localparam int DIV_DW  = (DIMS_W > ITER_W) ? DIMS_W : ITER_W;
  localparam int DIV_CW  = $clog2(DIV_NW);
  localparam int START_W = DIV_NW + 2;
  localparam int SUM_W   = PRD_W + 2;
  localparam int SQ_W    = 2 * CX_W - FRAC_BITS;

  localparam logic [SQ_W:0] ESC_MAG =
    {{(SQ_W - FRAC_BITS - 2){1'b0}}, 1'b1, {(FRAC_BITS + 2){1'b0}}};
  localparam logic [COLOUR_W-1:0] GREY_MULT = 24'h010101;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER   = 3'd0,
    REG_CENTER_X   = 3'd1,
    REG_CENTER_Y   = 3'd2,
    REG_SCALE_Y    = 3'd3,
    REG_SAMPLES    = 3'd4,
    REG_IMG_WIDTH  = 3'd5,
    REG_IMG_HEIGHT = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DIV_SCX,
    DIV_DX,
    DIV_DY,
    DIV_AVG,
    DIV_LVL
  } div_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCX_GO,
    S_SCX_WT,
    S_DX_GO,
    S_DX_WT,
    S_DY_GO,
    S_DY_WT,
    S_PIX,
    S_CMUL,
    S_CSET,
    S_SQ,
    S_ITER,
    S_AVG_GO,
    S_AVG_WT,
    S_LVL_GO,
    S_LVL_WT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ITER_W-1:0]         max_iterations;
    logic signed [CX_W-1:0]    center_x;
    logic signed [CX_W-1:0]    center_y;
    logic [SCALE_W-1:0]        scale_y;
    logic [S_CFG_W-1:0]        samples_per_axis;
    logic [DIM_W-1:0]          image_width;
    logic [DIM_W-1:0]          image_height;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_store;
    logic     pix_init;
    logic     cmul;
    logic     cset;
    logic     sq;
    logic     iter;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;
    logic last_sub;
  } stat_t;

  // Clamp to the signed 32-bit range.
  function automatic logic signed [CX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-CX_W:0] top;
    top = v[SUM_W-1:CX_W-1];
    if (top == '0 || top == '1) begin
      return v[CX_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(CX_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CX_W-1){1'b1}}};
    end
  endfunction

endpackage

/* rtl/mpc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module mpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mpc_pkg::DIV_NW-1:0]  dividend,
  input  logic [mpc_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [mpc_pkg::DIV_NW-1:0]  quotient
);
  import mpc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] d_r;

  logic [DIV_DW:0]   trial;
  logic              q_bit;
  logic [DIV_DW-1:0] rem_nxt;
  logic [DIV_NW-1:0] q_nxt;

  always_comb begin
    trial = {rem_r, q_r[DIV_NW-1]};
    q_bit = (trial >= {1'b0, d_r});
    if (q_bit) begin
      rem_nxt = DIV_DW'(trial - {1'b0, d_r});
    end else begin
      rem_nxt = trial[DIV_DW-1:0];
    end
    q_nxt = {q_r[DIV_NW-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CW'(DIV_NW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - DIV_CW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* rtl/mpc_datapath.sv */
// Datapath: plane mapping, escape iteration, accumulation and grey level.
module mpc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpc_pkg::cfg_t                 cfg,
  input  mpc_pkg::cmd_t                 cmd,
  input  logic [mpc_pkg::PIX_W-1:0]     pixel_x,
  input  logic [mpc_pkg::PIX_W-1:0]     pixel_y,
  output mpc_pkg::stat_t                stat,
  output logic [mpc_pkg::COLOUR_W-1:0]  colour
);
  import mpc_pkg::*;

  // effective settings, latched at load
  logic [ITER_W-1:0] lim_eff, lim_r;
  logic [DIM_W-1:0]  w_eff, h_eff, w_r, h_r;
  logic [S_W-1:0]    s_eff, s_r;
  logic [PXS_W-1:0]  px_s, py_s, px_s_r, py_s_r;
  logic [DIV_NW-1:0] scw, prod_r;

  logic [DIMS_W-1:0] ws, hs;
  logic [SS_W-1:0]   ss;

  logic [DIV_NW-1:0]         sc_x_r;
  logic signed [START_W-1:0] start_x_r, start_y_r;
  logic [SCALE_W-1:0]        dx_r, dy_r;
  logic [ITER_W-1:0]         avg_r;
  logic [ITER_W+CL_W-1:0]    avg_cl;
  logic [LVL_W-1:0]          lvl_r;

  logic [DIV_NW-1:0] div_dvd, div_q;
  logic [DIV_DW-1:0] div_dvs;
  logic              div_done;

  logic [S_W-1:0]   sx_r, sy_r;
  logic [TOT_W-1:0] total_r;
  logic [PXS_W-1:0] sub_x, sub_y;
  logic [PRD_W-1:0] mul_x, mul_y, prod_x_r, prod_y_r;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  logic signed [CX_W-1:0]   cr_r, ci_r, x_r, y_r, x_nxt, y_nxt;
  logic signed [2*CX_W-1:0] xx_p_r, yy_p_r, xy_p_r;
  logic signed [SQ_W-1:0]   xx, yy;
  logic [SQ_W:0]            mag;
  logic signed [SUM_W-1:0]  nx_sum, ny_sum;
  logic [CNT_W-1:0]         count_r;
  logic                     escape, over;

  always_comb begin
    lim_eff = (cfg.max_iterations == '0) ? ITER_W'(1) : cfg.max_iterations;
    w_eff   = (cfg.image_width == '0) ? DIM_W'(1) : cfg.image_width;
    h_eff   = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
    if (cfg.samples_per_axis == '0) begin
      s_eff = S_W'(1);
    end else if (int'(cfg.samples_per_axis) > MAX_SAMPLES) begin
      s_eff = S_W'(MAX_SAMPLES);
    end else begin
      s_eff = S_W'(cfg.samples_per_axis);
    end
  end

  assign px_s = pixel_x * s_eff;
  assign py_s = pixel_y * s_eff;
  assign scw  = cfg.scale_y * w_eff;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lim_r     <= lim_eff;
      w_r       <= w_eff;
      h_r       <= h_eff;
      s_r       <= s_eff;
      px_s_r    <= px_s;
      py_s_r    <= py_s;
      prod_r    <= scw;
      start_y_r <= START_W'(cfg.center_y) - START_W'(cfg.scale_y >> 1);
    end
  end

  assign ws     = w_r * s_r;
  assign hs     = h_r * s_r;
  assign ss     = s_r * s_r;
  assign avg_cl = avg_r * CL_W'(COLOUR_LEVELS);

  always_comb begin
    case (cmd.div_sel)
      DIV_SCX: begin
        div_dvd = prod_r;
        div_dvs = DIV_DW'(h_r);
      end
      DIV_DX: begin
        div_dvd = sc_x_r;
        div_dvs = DIV_DW'(ws);
      end
      DIV_DY: begin
        div_dvd = DIV_NW'(cfg.scale_y);
        div_dvs = DIV_DW'(hs);
      end
      DIV_AVG: begin
        div_dvd = DIV_NW'(total_r);
        div_dvs = DIV_DW'(ss);
      end
      DIV_LVL: begin
        div_dvd = DIV_NW'(avg_cl);
        div_dvs = DIV_DW'(lim_r);
      end
      default: begin
        div_dvd = '0;
        div_dvs = DIV_DW'(1);
      end
    endcase
  end

  mpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_SCX: begin
          sc_x_r    <= div_q;
          start_x_r <= START_W'(cfg.center_x) - START_W'(div_q >> 1);
        end
        DIV_DX:  dx_r  <= SCALE_W'(div_q);
        DIV_DY:  dy_r  <= SCALE_W'(div_q);
        DIV_AVG: avg_r <= ITER_W'(div_q);
        DIV_LVL: lvl_r <= LVL_W'(div_q) & LVL_W'(COLOUR_LEVELS - 1);
        default: ;
      endcase
    end
  end

  // subpixel point c
  assign sub_x = px_s_r + PXS_W'(sx_r);
  assign sub_y = py_s_r + PXS_W'(sy_r);
  assign mul_x = sub_x * dx_r;
  assign mul_y = sub_y * dy_r;
  assign sum_x = SUM_W'(start_x_r) + SUM_W'(prod_x_r);
  assign sum_y = SUM_W'(start_y_r) + SUM_W'(prod_y_r);

  // one escape step
  assign xx     = SQ_W'(xx_p_r >>> FRAC_BITS);
  assign yy     = SQ_W'(yy_p_r >>> FRAC_BITS);
  assign mag    = (SQ_W+1)'(xx) + (SQ_W+1)'(yy);
  assign escape = (mag >= ESC_MAG);
  assign over   = (count_r > {1'b0, lim_r});
  assign nx_sum = SUM_W'(xx) - SUM_W'(yy) + SUM_W'(cr_r);
  assign ny_sum = SUM_W'(xy_p_r >>> (FRAC_BITS - 1)) + SUM_W'(ci_r);
  assign x_nxt  = sat32(nx_sum);
  assign y_nxt  = sat32(ny_sum);

  always_ff @(posedge clk) begin
    if (cmd.pix_init) begin
      sx_r    <= '0;
      sy_r    <= '0;
      total_r <= '0;
    end
    if (cmd.cmul) begin
      prod_x_r <= mul_x;
      prod_y_r <= mul_y;
    end
    if (cmd.cset) begin
      cr_r    <= sat32(sum_x);
      ci_r    <= sat32(sum_y);
      x_r     <= sat32(sum_x);
      y_r     <= sat32(sum_y);
      count_r <= '0;
    end
    if (cmd.sq) begin
      xx_p_r <= x_r * x_r;
      yy_p_r <= y_r * y_r;
      xy_p_r <= x_r * y_r;
    end
    if (cmd.iter) begin
      if (escape || over) begin
        if (!over) begin
          total_r <= total_r + TOT_W'(count_r);
        end
        if (sx_r == s_r - S_W'(1)) begin
          sx_r <= '0;
          sy_r <= sy_r + S_W'(1);
        end else begin
          sx_r <= sx_r + S_W'(1);
        end
      end else begin
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  assign stat.div_done = div_done;
  assign stat.stop     = escape || over;
  assign stat.last_sub = (sx_r == s_r - S_W'(1)) && (sy_r == s_r - S_W'(1));

  assign colour = lvl_r * GREY_MULT;

endmodule

/* rtl/mpc_ctrl.sv */
// Controller: sequences setup divisions, subpixel iteration and the final level.
module mpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  input  mpc_pkg::stat_t stat,
  output logic           in_ready,
  output mpc_pkg::cmd_t  cmd
);
  import mpc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.div_sel = DIV_SCX;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCX_GO;
        end
      end
      S_SCX_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SCX_WT;
      end
      S_SCX_WT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DX_GO;
        end
      end
      S_DX_GO: begin
        cmd.div_sel   = DIV_DX;
        cmd.div_start = 1'b1;
        state_nxt     = S_DX_WT;
      end
      S_DX_WT: begin
        cmd.div_sel = DIV_DX;
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.div_sel   = DIV_DY;
        cmd.div_start = 1'b1;
        state_nxt     = S_DY_WT;
      end
      S_DY_WT: begin
        cmd.div_sel = DIV_DY;
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_PIX;
        end
      end
      S_PIX: begin
        cmd.pix_init = 1'b1;
        state_nxt    = S_CMUL;
      end
      S_CMUL: begin
        cmd.cmul  = 1'b1;
        state_nxt = S_CSET;
      end
      S_CSET: begin
        cmd.cset  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (stat.stop) begin
          state_nxt = stat.last_sub ? S_AVG_GO : S_CMUL;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_AVG_GO: begin
        cmd.div_sel   = DIV_AVG;
        cmd.div_start = 1'b1;
        state_nxt     = S_AVG_WT;
      end
      S_AVG_WT: begin
        cmd.div_sel = DIV_AVG;
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_LVL_GO;
        end
      end
      S_LVL_GO: begin
        cmd.div_sel   = DIV_LVL;
        cmd.div_start = 1'b1;
        state_nxt     = S_LVL_WT;
      end
      S_LVL_WT: begin
        cmd.div_sel = DIV_LVL;
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mandelbrot_pixel_colour.sv */
// Top level of the supersampled Mandelbrot escape-time grey colour block.
//
// Channels: in_ (pixel_x, pixel_y) and out_ (colour) are valid/ready words;
// cfg_ writes one setting register per word, index cfg_index, data cfg_data,
// and is always ready. Settings must be changed only while no pixel is in
// flight; the block does not enforce this. One pixel is worked on at a time.
// A subpixel's iteration count is at most limit + 1. Each escape step
// squares, then updates; the five divisions share a one-bit-per-cycle
// divider of 44 bits. The next pixel can be accepted in the cycle after
// the colour is loaded.
// The result sits in an output register, so the next pixel is accepted while
// the previous colour waits; if it still waits when the next one finishes,
// the controller holds in its final state until out_ready frees the register.
// Reset (rst_n low, synchronous) loads the default settings, empties the
// output register and returns the controller to idle.
`include "mandelbrot_pixel_colour_macros.svh"

module mandelbrot_pixel_colour (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mpc_pkg::PIX_W-1:0]        in_pixel_x,
  input  logic [mpc_pkg::PIX_W-1:0]        in_pixel_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpc_pkg::COLOUR_W-1:0]     out_colour,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mpc_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  logic                out_valid_r;
  logic [COLOUR_W-1:0] out_colour_r;
  logic [COLOUR_W-1:0] dp_colour;
  logic                out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations   <= ITER_W'(255);
      cfg_r.center_x         <= 32'shF800_0000;
      cfg_r.center_y         <= '0;
      cfg_r.scale_y          <= SCALE_W'(32'h2000_0000);
      cfg_r.samples_per_axis <= S_CFG_W'(1);
      cfg_r.image_width      <= DIM_W'(640);
      cfg_r.image_height     <= DIM_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_MAX_ITER:   cfg_r.max_iterations   <= cfg_data[ITER_W-1:0];
        REG_CENTER_X:   cfg_r.center_x         <= cfg_data[CX_W-1:0];
        REG_CENTER_Y:   cfg_r.center_y         <= cfg_data[CX_W-1:0];
        REG_SCALE_Y:    cfg_r.scale_y          <= cfg_data[SCALE_W-1:0];
        REG_SAMPLES:    cfg_r.samples_per_axis <= cfg_data[S_CFG_W-1:0];
        REG_IMG_WIDTH:  cfg_r.image_width      <= cfg_data[DIM_W-1:0];
        REG_IMG_HEIGHT: cfg_r.image_height     <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;

  mpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  mpc_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .stat    (stat),
    .colour  (dp_colour)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_colour_r <= dp_colour;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_colour = out_colour_r;

  `MPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "pixel taken while busy")
  `MPC_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready, "colour overwritten")
  `MPC_ASSERT_SAME(a_idle_quiet, in_ready, !cmd.iter && !cmd.div_start && !cmd.out_load, "work while idle")

endmodule
